@@ design/skvt_pkg.sv @@
// skvt_pkg: beat types, request/status codes and controller/datapath
// command and status structs for the sorted key/value table.
// No dependencies.
package skvt_pkg;

    localparam int POS_W = 5;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_UPDATE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // datapath operations
    localparam logic [3:0] DP_NOP    = 4'd0;
    localparam logic [3:0] DP_TAKE   = 4'd1;
    localparam logic [3:0] DP_SRCH   = 4'd2;
    localparam logic [3:0] DP_UP_LD  = 4'd3;
    localparam logic [3:0] DP_DN_LD  = 4'd4;
    localparam logic [3:0] DP_MOVE   = 4'd5;
    localparam logic [3:0] DP_PUT_KV = 4'd6;
    localparam logic [3:0] DP_PUT_V  = 4'd7;
    localparam logic [3:0] DP_DEC    = 4'd8;
    localparam logic [3:0] DP_RES    = 4'd9;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [7:0]  key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } rsp_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
        logic       keep_val;
    } dp_cmd_t;

    typedef struct packed {
        logic srch_done;
        logic move_done;
        logic full;
        logic eq;
    } dp_st_t;

endpackage

@@ design/skvt_datapath.sv @@
// skvt_datapath: key/value memories, fill count, walk unit for search and
// shifting, result register. Depends on skvt_pkg.
module skvt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  skvt_pkg::req_t                     s_data,
    input  skvt_pkg::dp_cmd_t                  cmd,
    output skvt_pkg::dp_st_t                   st,
    output logic [$clog2(CAPACITY+1)-1:0]      fill_count,
    output skvt_pkg::rsp_t                     res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [7:0]  key_mem [CAPACITY];
    logic signed [31:0] val_mem [CAPACITY];

    logic [CW-1:0]      fill_reg;
    logic               pend_reg;
    logic signed [7:0]  key_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      left_reg;
    logic [CW-1:0]      tag_reg;
    logic               up_reg;
    logic signed [7:0]  rkey_reg;
    logic signed [31:0] rval_reg;
    logic [CW-1:0]      pos_reg;
    logic               eq_reg;
    logic signed [31:0] old_reg;
    skvt_pkg::rsp_t     res_reg;

    logic walking;
    logic issue;
    logic srch_hit;
    logic walk_end;
    logic res_ok;

    assign walking  = (cmd.op == skvt_pkg::DP_SRCH) || (cmd.op == skvt_pkg::DP_MOVE);
    assign issue    = walking && (left_reg != '0);
    assign srch_hit = pend_reg && (rkey_reg >= key_reg);
    assign walk_end = (left_reg == '0) && !pend_reg;
    assign res_ok   = (cmd.status == skvt_pkg::ST_OK);

    assign st.srch_done = srch_hit || walk_end;
    assign st.move_done = walk_end;
    assign st.full      = (fill_reg == CW'(CAPACITY));
    assign st.eq        = eq_reg;
    assign fill_count   = fill_reg;
    assign res          = res_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                skvt_pkg::DP_TAKE,
                skvt_pkg::DP_UP_LD,
                skvt_pkg::DP_DN_LD:  pend_reg <= 1'b0;
                skvt_pkg::DP_SRCH,
                skvt_pkg::DP_MOVE:   pend_reg <= issue;
                skvt_pkg::DP_PUT_KV: fill_reg <= fill_reg + CW'(1);
                skvt_pkg::DP_DEC:    fill_reg <= fill_reg - CW'(1);
                default: ;
            endcase
        end
    end

    // walk pointers, captured request, search result, output beat
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            skvt_pkg::DP_TAKE: begin
                key_reg  <= s_data.key;
                val_reg  <= s_data.value;
                ptr_reg  <= '0;
                left_reg <= fill_reg;
                up_reg   <= 1'b0;
            end
            skvt_pkg::DP_SRCH: begin
                if (issue) begin
                    ptr_reg  <= ptr_reg + CW'(1);
                    left_reg <= left_reg - CW'(1);
                    tag_reg  <= ptr_reg;
                end
                if (srch_hit || walk_end) begin
                    pos_reg <= srch_hit ? tag_reg : fill_reg;
                    eq_reg  <= srch_hit && (rkey_reg == key_reg);
                    old_reg <= rval_reg;
                end
            end
            skvt_pkg::DP_UP_LD: begin
                ptr_reg  <= fill_reg - CW'(1);
                left_reg <= fill_reg - pos_reg;
                up_reg   <= 1'b1;
            end
            skvt_pkg::DP_DN_LD: begin
                ptr_reg  <= pos_reg + CW'(1);
                left_reg <= fill_reg - pos_reg - CW'(1);
                up_reg   <= 1'b0;
            end
            skvt_pkg::DP_MOVE: begin
                if (issue) begin
                    ptr_reg  <= up_reg ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
                    left_reg <= left_reg - CW'(1);
                    tag_reg  <= up_reg ? ptr_reg + CW'(1) : ptr_reg - CW'(1);
                end
            end
            skvt_pkg::DP_RES: begin
                res_reg.status      <= cmd.status;
                res_reg.value_out   <= (res_ok && cmd.keep_val) ? old_reg : '0;
                res_reg.position    <= res_ok ? skvt_pkg::POS_W'(pos_reg) : '0;
                res_reg.entry_count <= skvt_pkg::POS_W'(fill_reg);
            end
            default: ;
        endcase
    end

    // memory read port, data registered
    always_ff @(posedge aclk) begin
        if (issue) begin
            rkey_reg <= key_mem[ptr_reg[AW-1:0]];
            rval_reg <= val_mem[ptr_reg[AW-1:0]];
        end
    end

    // memory write port: shifted entry, new entry or new value
    always_ff @(posedge aclk) begin
        if ((cmd.op == skvt_pkg::DP_MOVE) && pend_reg) begin
            key_mem[tag_reg[AW-1:0]] <= rkey_reg;
            val_mem[tag_reg[AW-1:0]] <= rval_reg;
        end else if (cmd.op == skvt_pkg::DP_PUT_KV) begin
            key_mem[pos_reg[AW-1:0]] <= key_reg;
            val_mem[pos_reg[AW-1:0]] <= val_reg;
        end else if (cmd.op == skvt_pkg::DP_PUT_V) begin
            val_mem[pos_reg[AW-1:0]] <= val_reg;
        end
    end

endmodule

@@ design/skvt_ctrl.sv @@
// skvt_ctrl: request sequencer; drives datapath commands and beat valid/ready.
// Depends on skvt_pkg.
module skvt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         req_type,
    output logic               m_valid,
    input  logic               m_ready,
    input  skvt_pkg::dp_st_t   st,
    output skvt_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] req_reg, req_next;
    logic [1:0] status_reg, status_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = skvt_pkg::DP_NOP;
        cmd.status   = status_reg;
        cmd.keep_val = (req_reg != skvt_pkg::REQ_INSERT);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op   = skvt_pkg::DP_TAKE;
                    req_next = req_type;
                    if ((req_type == skvt_pkg::REQ_INSERT) && st.full) begin
                        status_next = skvt_pkg::ST_FULL;
                        state_next  = S_RES;
                    end else begin
                        status_next = skvt_pkg::ST_OK;
                        state_next  = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                cmd.op = skvt_pkg::DP_SRCH;
                if (st.srch_done) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (req_reg == skvt_pkg::REQ_INSERT) begin
                    cmd.op     = skvt_pkg::DP_UP_LD;
                    state_next = S_MOVE;
                end else if (!st.eq) begin
                    status_next = skvt_pkg::ST_MISSING;
                    state_next  = S_RES;
                end else if (req_reg == skvt_pkg::REQ_REMOVE) begin
                    cmd.op     = skvt_pkg::DP_DN_LD;
                    state_next = S_MOVE;
                end else if (req_reg == skvt_pkg::REQ_UPDATE) begin
                    cmd.op     = skvt_pkg::DP_PUT_V;
                    state_next = S_RES;
                end else begin
                    state_next = S_RES;
                end
            end
            S_MOVE: begin
                cmd.op = skvt_pkg::DP_MOVE;
                if (st.move_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.op     = (req_reg == skvt_pkg::REQ_INSERT) ? skvt_pkg::DP_PUT_KV
                                                               : skvt_pkg::DP_DEC;
                state_next = S_RES;
            end
            S_RES: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = skvt_pkg::DP_RES;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            req_reg     <= skvt_pkg::REQ_INSERT;
            status_reg  <= skvt_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/sorted_key_value_table_unit.sv @@
// sorted_key_value_table_unit: top level of the sorted key/value table.
// Instantiates skvt_ctrl and skvt_datapath; uses skvt_pkg.
//
// Holds up to CAPACITY entries sorted ascending by signed 8-bit key, in a
// pair of single-port-write memories. Each request beat (insert, remove,
// lookup, update) gives exactly one result beat. One request is worked at a
// time: the search walks the table from index 0, one memory read per cycle,
// and stops at the first key not below the request key, or at the end of
// the table. Insert then shifts the entries from the slot upward up by one
// and remove shifts the entries above the slot down, one entry per cycle
// through the registered read port. An insert into a full table skips
// the search and answers with the full status. The result register frees
// the input side: the next request beat is taken as soon as the current
// one is finished, even while its result beat still waits for m_ready.
// Memories need no clearing; entries are only read below the fill count.
module sorted_key_value_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  skvt_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output skvt_pkg::rsp_t  m_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    skvt_pkg::dp_cmd_t dp_cmd;
    skvt_pkg::dp_st_t  dp_st;
    logic [CW-1:0]     fill;

    // sequencer: one request at a time
    skvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .st       (dp_st),
        .cmd      (dp_cmd)
    );

    // memories, walk unit and result register
    skvt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .cmd        (dp_cmd),
        .st         (dp_st),
        .fill_count (fill),
        .res        (m_data)
    );

    // fill count stays within the table
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // fill count moves by one entry at most per cycle
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(fill) |->
            (fill == $past(fill) + CW'(1)) || (fill == $past(fill) - CW'(1)))
        else $error("fill count jumped");

    // a miss reports no value and no position
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == skvt_pkg::ST_MISSING) |->
            (m_data.value_out == '0) && (m_data.position == '0))
        else $error("miss result carries data");

endmodule
